// ----- hw/rtl/flla_pkg.sv -----
// flla_pkg: widths and fixed-point constants shared by the fast log lanes
// no dependencies
package flla_pkg;

  localparam int NUM_FIELDS = 8;    // lanes carried by one item
  localparam int IN_W       = 32;   // raw single-precision pattern
  localparam int OUT_W      = 26;   // signed result width
  localparam int Y_W        = 40;   // q28 intermediate width
  localparam int D_W        = 29;   // divisor width
  localparam int DIV_STEPS  = 30;   // quotient bits, one per stage
  localparam int LANE_LAT   = 34;   // register stages inside one lane

  // q28 coefficients
  localparam logic signed [Y_W-1:0] K_BIAS = 40'sd33346532763;
  localparam logic [28:0]           K_LIN  = 29'd402124447;
  localparam logic [28:0]           K_OFS  = 29'd94513093;
  localparam logic [23:0]           K_LN2  = 24'd11629080;   // q24
  // dividend of the rational term: 1.72587999 in q28, shifted up by 28
  localparam logic [56:0]           DIV_NUM = {29'd463287382, 28'd0};

  localparam logic signed [63:0] SAT_MAX = 64'sd33554431;
  localparam logic signed [63:0] SAT_MIN = -64'sd33554432;

endpackage

// ----- hw/rtl/flla_lane.sv -----
// flla_lane: one pipelined fast log lane with a bit-per-stage divider
// depends on flla_pkg
module flla_lane
  import flla_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic                    func,
  input  logic [IN_W-1:0]         bits,
  output logic signed [OUT_W-1:0] res
);

  localparam int SH_L2 = 28 - FRAC_BITS;
  localparam int SH_LN = 52 - FRAC_BITS;
  localparam logic [63:0] HALF_L2 = 64'd1 << (SH_L2 - 1);
  localparam logic [45:0] HALF_LN = 46'd1 << (SH_LN - 1);

  // stage 1: linear product, biased integer part, divisor
  logic [51:0]           p1_r, p1_nxt;
  logic signed [Y_W-1:0] t1_r, t1_nxt;
  logic [D_W-1:0]        d1_r, d1_nxt;
  logic                  fn1_r;

  always_comb begin
    p1_nxt = K_LIN * bits[22:0];
    t1_nxt = $signed({{3{bits[31]}}, bits, 5'd0}) - K_BIAS;
    d1_nxt = K_OFS + {1'b0, 1'b1, bits[22:0], 4'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= p1_nxt;
      t1_r  <= t1_nxt;
      d1_r  <= d1_nxt;
      fn1_r <= func;
    end
  end

  // divider stages, linear term folded in at the first one
  logic [D_W-1:0]        r_r  [DIV_STEPS];
  logic [D_W-1:0]        d_r  [DIV_STEPS];
  logic [DIV_STEPS-1:0]  q_r  [DIV_STEPS];
  logic signed [Y_W-1:0] y_r  [DIV_STEPS];
  logic                  fn_r [DIV_STEPS];

  logic [52:0]           lin_sum;
  logic signed [Y_W-1:0] ypre;

  always_comb begin
    lin_sum = {1'b0, p1_r} + {1'b0, K_LIN, 23'd0};
    ypre    = t1_r - $signed({11'd0, lin_sum[52:24]});
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [D_W-1:0]        rin, rout;
    logic [D_W-1:0]        din;
    logic [DIV_STEPS-1:0]  qin;
    logic signed [Y_W-1:0] yin;
    logic                  fin;
    logic [D_W+1:0]        diff;

    if (j == 0) begin : g_first
      assign rin = {2'd0, DIV_NUM[56:30]};
      assign din = d1_r;
      assign qin = '0;
      assign yin = ypre;
      assign fin = fn1_r;
    end else begin : g_next
      assign rin = r_r[j-1];
      assign din = d_r[j-1];
      assign qin = q_r[j-1];
      assign yin = y_r[j-1];
      assign fin = fn_r[j-1];
    end

    always_comb begin
      diff = {1'b0, rin, DIV_NUM[DIV_STEPS-1-j]} - {2'b0, din};
      rout = diff[D_W+1] ? rin : diff[D_W-1:0];
      if (diff[D_W+1]) begin
        rout = rin;
      end
    end

    // restore when the trial subtract goes negative
    logic [D_W-1:0] rsel;
    assign rsel = diff[D_W+1] ? {rin[D_W-2:0], DIV_NUM[DIV_STEPS-1-j]} : rout;

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[j]  <= rsel;
        d_r[j]  <= din;
        q_r[j]  <= {qin[DIV_STEPS-2:0], ~diff[D_W+1]};
        y_r[j]  <= yin;
        fn_r[j] <= fin;
      end
    end
  end

  // q28 result
  logic signed [Y_W-1:0] y_f_r;
  logic                  fn_f_r;

  always_ff @(posedge clk) begin
    if (en) begin
      y_f_r  <= y_r[DIV_STEPS-1] - $signed({10'd0, q_r[DIV_STEPS-1]});
      fn_f_r <= fn_r[DIV_STEPS-1];
    end
  end

  // ln2 scaling in two partial products
  logic signed [20:0]    yh;
  logic signed [24:0]    kln;
  logic signed [45:0]    ph_r, ph_nxt;
  logic [45:0]           pl_r, pl_nxt;
  logic signed [Y_W-1:0] y_m_r;
  logic                  fn_m_r;

  always_comb begin
    yh     = y_f_r[39:19];
    kln    = $signed({1'b0, K_LN2});
    ph_nxt = yh * kln;
    pl_nxt = ({27'd0, y_f_r[18:0]} * {22'd0, K_LN2}) + HALF_LN;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r   <= ph_nxt;
      pl_r   <= pl_nxt;
      y_m_r  <= y_f_r;
      fn_m_r <= fn_f_r;
    end
  end

  // round, shift, select log2 or ln, saturate
  logic signed [63:0] p_ln, p_l2, p_sel;
  logic signed [OUT_W-1:0] res_r, res_nxt;

  always_comb begin
    p_ln = ($signed({{18{ph_r[45]}}, ph_r}) <<< 19) + $signed({18'd0, pl_r});
    p_ln = p_ln >>> SH_LN;
    p_l2 = $signed({{24{y_m_r[Y_W-1]}}, y_m_r}) + $signed(HALF_L2);
    p_l2 = p_l2 >>> SH_L2;
    p_sel = fn_m_r ? p_ln : p_l2;
    if (p_sel > SAT_MAX) begin
      res_nxt = SAT_MAX[OUT_W-1:0];
    end else if (p_sel < SAT_MIN) begin
      res_nxt = SAT_MIN[OUT_W-1:0];
    end else begin
      res_nxt = p_sel[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ----- hw/rtl/fast_log_approx_lanes.sv -----
// fast_log_approx_lanes: top level, lane array with output register and skid
// depends on flla_pkg and flla_lane
//
// usage
//   input stream: in_tdata carries eight raw single-precision patterns,
//   in_tuser selects the function (0 log2, 1 natural log). an item is taken
//   when in_tvalid and in_tready are both high.
//   result stream: out_tdata carries eight signed 26-bit logs with
//   FRAC_BITS fraction bits, saturated; lanes at LANES and above read 0.
//   throughput: one item per cycle while the skid is empty, set by the lane
//   pipeline, each lane a 30-stage restoring divider (one quotient bit per
//   stage) plus four stages for the products, rounding and saturation.
//   path: an accepted item passes the 34 lane stages, the last of which
//   feeds the output register that drives out_tvalid.
//   reset: rst_n, synchronous, clears valid pipeline, output and skid flags.
//   stall: when the output register is full and out_tready is low, the item
//   leaving the pipeline parks in a skid register; in_tready then drops until
//   the skid drains, and the whole pipeline holds in place.
module fast_log_approx_lanes
  import flla_pkg::*;
#(
  parameter int LANES     = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [255:0] in_tdata,   // value_0 .. value_7, 32 bits each
  input  logic [0:0]   in_tuser,   // func
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [207:0] out_tdata   // log_0 .. log_7, 26 bits each
);

  localparam int OD_W = NUM_FIELDS * OUT_W;

  logic en;
  logic skid_vld_r;
  assign en        = ~skid_vld_r;
  assign in_tready = en;

  // valid tag travels alongside the lane payload
  logic [LANE_LAT-1:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LANE_LAT-2:0], in_tvalid};
    end
  end

  // lane array
  logic [OD_W-1:0] pipe_data;
  for (genvar i = 0; i < NUM_FIELDS; i++) begin : g_lane
    if (i < LANES) begin : g_on
      logic signed [OUT_W-1:0] res;
      flla_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
        .clk  (clk),
        .en   (en),
        .func (in_tuser[0]),
        .bits (in_tdata[i*IN_W +: IN_W]),
        .res  (res)
      );
      assign pipe_data[i*OUT_W +: OUT_W] = res;
    end else begin : g_off
      assign pipe_data[i*OUT_W +: OUT_W] = '0;
    end
  end

  // merge: output register plus one skid entry
  logic            out_vld_r;
  logic [OD_W-1:0] out_data_r, skid_data_r;
  logic            pop, pv;
  assign pop = out_vld_r & out_tready;
  assign pv  = v_r[LANE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (pv) begin
      if (!out_vld_r || pop) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (pv) begin
      if (!out_vld_r || pop) begin
        out_data_r <= pipe_data;
      end else begin
        skid_data_r <= pipe_data;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- tb/sv/fast_log_approx_lanes_tb.sv -----
// fast_log_approx_lanes_tb: self-checking bench for the eight-lane fast log block
// drives random and directed patterns, predicts each lane in q28 fixed point
// depends on flla_pkg and the fast_log_approx_lanes rtl
`timescale 1ns / 100ps

module fast_log_approx_lanes_tb;
  import flla_pkg::*;

  localparam int N_RANDOM   = 1200;
  localparam int N_DIRECTED = 12;
  localparam int CYCLE_MAX  = 200000;
  localparam int DRAIN_WAIT = 60;

  typedef enum logic [0:0] {FN_LOG2 = 1'b0, FN_LN = 1'b1} log_fn_t;

  typedef struct {
    log_fn_t     fn;
    logic [31:0] pattern;
    logic        has_known;
    logic [25:0] known;      // expected lane value; the bench inverts the pattern in one lane
  } stim_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [255:0] in_tdata;    // value_0 .. value_7, 32 bits each
  logic [0:0]   in_tuser;    // func
  logic         out_tvalid;
  logic         out_tready;
  logic [207:0] out_tdata;   // log_0 .. log_7, 26 bits each

  fast_log_approx_lanes dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  // 4 ns period
  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  logic [207:0] expected_logs[$];
  int           errors = 0;
  int           items_sent = 0;
  int           results_seen = 0;
  int           ln_items = 0;
  longint       cycles = 0;
  stim_row_t    table_rows[N_DIRECTED];

  // add half a step, floor by 2^s, then clamp to the 26-bit range
  function automatic logic [25:0] round_clamp(input logic signed [127:0] v, input int s);
    logic signed [127:0] r;
    r = (v + (128'sd1 <<< (s - 1))) >>> s;
    if (r > 128'sd33554431) r = 128'sd33554431;
    if (r < -128'sd33554432) r = -128'sd33554432;
    return r[25:0];
  endfunction

  // one lane of the approximation, q28 intermediates
  function automatic logic [25:0] approx_lane_log(input logic [31:0] bits, input log_fn_t fn);
    logic signed [127:0] t28, m28, lin, quo, y28;
    t28 = $signed({{96{bits[31]}}, bits}) * 128'sd32;
    m28 = 128'sd134217728 + $signed({105'd0, bits[22:0]}) * 128'sd16;
    lin = (128'sd402124447 * m28) >>> 28;
    quo = (128'sd463287382 <<< 28) / (128'sd94513093 + m28);
    y28 = t28 - 128'sd33346532763 - lin - quo;
    if (fn == FN_LN) return round_clamp(y28 * 128'sd11629080, 52 - 16);
    return round_clamp(y28, 28 - 16);
  endfunction

  function automatic logic [207:0] approx_vec_log(input logic [255:0] pats, input log_fn_t fn);
    logic [207:0] r;
    for (int i = 0; i < NUM_FIELDS; i++) r[i*26 +: 26] = approx_lane_log(pats[i*32 +: 32], fn);
    return r;
  endfunction

  // sends one item, waiting for the handshake; gaps come from maybe_gap
  task automatic send_item(input logic [255:0] pats, input log_fn_t fn);
    in_tvalid <= 1'b1;
    in_tdata  <= pats;
    in_tuser  <= fn;
    expected_logs.push_back(approx_vec_log(pats, fn));
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (fn == FN_LN) ln_items++;
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // receiver stall pattern: long ready stretches, sometimes choppy
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (cycles % 512 < 200) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [207:0] exp_v;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_logs.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        exp_v = expected_logs.pop_front();
        for (int i = 0; i < NUM_FIELDS; i++) begin
          if (out_tdata[i*26 +: 26] !== exp_v[i*26 +: 26]) begin
            $display("%0t: lane %0d expected %h actual %h", $time, i,
                     exp_v[i*26 +: 26], out_tdata[i*26 +: 26]);
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [255:0] pats;
    log_fn_t      fn;
    // directed table: zero, one, extremes of sign and exponent, inf, nan
    table_rows[0]  = '{FN_LOG2, 32'h3F80_0000, 1'b0, '0};
    table_rows[1]  = '{FN_LN,   32'h3F80_0000, 1'b0, '0};
    table_rows[2]  = '{FN_LOG2, 32'h0000_0000, 1'b0, '0};
    table_rows[3]  = '{FN_LN,   32'h0000_0000, 1'b0, '0};
    table_rows[4]  = '{FN_LOG2, 32'h7FFF_FFFF, 1'b0, '0};
    table_rows[5]  = '{FN_LN,   32'h7FFF_FFFF, 1'b0, '0};
    table_rows[6]  = '{FN_LOG2, 32'h8000_0000, 1'b0, '0};
    table_rows[7]  = '{FN_LN,   32'hFFFF_FFFF, 1'b0, '0};
    table_rows[8]  = '{FN_LOG2, 32'h7F80_0000, 1'b0, '0};
    table_rows[9]  = '{FN_LN,   32'h7FC0_0000, 1'b0, '0};
    table_rows[10] = '{FN_LOG2, 32'h0080_0000, 1'b0, '0};
    table_rows[11] = '{FN_LOG2, 32'h4000_0000, 1'b0, '0};

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows put the pattern in every lane, then vary one lane
    foreach (table_rows[r]) begin
      pats = {8{table_rows[r].pattern}};
      pats[(r % 8)*32 +: 32] = ~table_rows[r].pattern;
      send_item(pats, table_rows[r].fn);
    end

    // random part: mostly plausible floats, some raw noise
    for (int n = 0; n < N_RANDOM; n++) begin
      for (int i = 0; i < NUM_FIELDS; i++) pats[i*32 +: 32] = $urandom();
      if ($urandom_range(0, 3) != 0)
        for (int i = 0; i < NUM_FIELDS; i++)
          pats[i*32+23 +: 9] = {1'b0, 8'($urandom_range(100, 154))};
      fn = log_fn_t'($urandom_range(0, 1));
      send_item(pats, fn);
      maybe_gap();
    end
    in_tvalid <= 1'b0;

    while (expected_logs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d items (%0d natural log), checked %0d results of eight lanes",
             items_sent, ln_items, results_seen);
    $display("covered sign, zero, inf, nan and exponent extremes with random stalls");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/flla_pkg.sv
hw/rtl/flla_lane.sv
hw/rtl/fast_log_approx_lanes.sv
tb/sv/fast_log_approx_lanes_tb.sv
